@@ design/bfca_pkg.sv @@
// ----------------------------------------------------------------------------
// bfca_pkg
// shared types, constants and codes of the bloom filter check/add block
// ----------------------------------------------------------------------------
package bfca_pkg;

  localparam int FILTER_BYTES  = 8192;
  localparam int MAX_KEY_BYTES = 32;
  localparam int MAX_PROBES    = 32;
  localparam int BYTE_AW       = $clog2(FILTER_BYTES);
  localparam int MAX_BITS      = FILTER_BYTES * 8;

  localparam logic [31:0] FIRST_SEED = 32'h9747b28c;
  localparam logic [31:0] MM_MUL     = 32'h5bd1e995;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_ABSENT    = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_BIT_COUNT = 2'd1;
  localparam logic [1:0] REG_HASH_CNT  = 2'd2;

  typedef enum logic [1:0] {
    JOB_DIRECT = 2'd0,
    JOB_CLEAR  = 2'd1,
    JOB_PROBE  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        add;
    logic [1:0]  status;
    logic [31:0] a;
    logic [31:0] b;
  } job_t;

  typedef struct packed {
    logic [16:0] nbits;
    logic [5:0]  probes;
  } probe_cfg_t;

endpackage

@@ design/bloom_filter_check_add.sv @@
// ----------------------------------------------------------------------------
// bloom_filter_check_add
// bloom filter with check, add and clear over a 65536 bit array
// ----------------------------------------------------------------------------
// After reset the block sweeps the 8192 byte bit array to zero, one byte per
// cycle, so in_full stays high until the sweep ends; configuration writes are
// taken during that time. For a check or add request each hash pass steps
// through K1, K2 and H for every 4-byte key word on a shared multiplier, then
// TAIL if the key ends in a partial word, then FIN. After taking the job, the
// back end handles each probe with the modulo steps of B_MOD, then reads one
// bit array byte in B_RD, checks it and, for an add, updates it in B_CHK.
// A clear request sweeps the whole bit array to zero.
// A two entry job queue lets the hash front end work on the next request while
// the back end probes, and one result register holds the answer until popped.
// ----------------------------------------------------------------------------
module bloom_filter_check_add (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  input  logic [5:0]  in_key_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import bfca_pkg::*;

  logic        enabled_r;
  logic [16:0] bit_count_r;
  logic [5:0]  hash_count_r;
  probe_cfg_t  pcfg;

  logic        front_busy;
  logic        init_busy;
  logic        in_accept;
  logic        job_push, job_pop, job_full, job_avail;
  job_t        front_job, head_job;
  logic        back_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      bit_count_r  <= 17'd65536;
      hash_count_r <= 6'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:    enabled_r    <= cfg_data[0];
        REG_BIT_COUNT: bit_count_r  <= cfg_data;
        REG_HASH_CNT:  hash_count_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // register values clipped to what the array and probe loop support
  always_comb begin
    if (bit_count_r == 17'd0) begin
      pcfg.nbits = 17'd1;
    end else if (bit_count_r > 17'(MAX_BITS)) begin
      pcfg.nbits = 17'(MAX_BITS);
    end else begin
      pcfg.nbits = bit_count_r;
    end
    pcfg.probes = (hash_count_r > 6'(MAX_PROBES)) ? 6'(MAX_PROBES) : hash_count_r;
  end

  assign in_full   = front_busy | init_busy;
  assign in_accept = in_push & ~in_full;

  bfca_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enabled    (enabled_r),
    .start      (in_accept),
    .busy       (front_busy),
    .command    (in_command),
    .key        ({in_key_word3, in_key_word2, in_key_word1, in_key_word0}),
    .key_length (in_key_length),
    .job_push   (job_push),
    .job        (front_job),
    .job_full   (job_full)
  );

  bfca_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .full     (job_full),
    .pop      (job_pop),
    .avail    (job_avail),
    .head_job (head_job)
  );

  bfca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pcfg       (pcfg),
    .job_avail  (job_avail),
    .job        (head_job),
    .job_pop    (job_pop),
    .init_busy  (init_busy),
    .out_valid  (back_valid),
    .out_status (out_status),
    .out_taken  (out_pop)
  );

  assign out_empty = ~back_valid;

endmodule

@@ design/bfca_ram.sv @@
// ----------------------------------------------------------------------------
// bfca_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bfca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bfca_jobq.sv @@
// ----------------------------------------------------------------------------
// bfca_jobq
// two entry queue of hashed jobs between the front and back ends
// ----------------------------------------------------------------------------
module bfca_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bfca_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          avail,
  output bfca_pkg::job_t head_job
);
  import bfca_pkg::*;

  job_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign head_job = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !full) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop && avail) begin
      rptr_nxt = ~rptr_r;
    end
    if ((push && !full) && !(pop && avail)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && avail)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

@@ design/bfca_front.sv @@
// ----------------------------------------------------------------------------
// bfca_front
// takes requests, sorts out direct answers and runs both murmurhash2 passes
// ----------------------------------------------------------------------------
module bfca_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           enabled,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     command,
  input  logic [255:0]   key,
  input  logic [5:0]     key_length,
  output logic           job_push,
  output bfca_pkg::job_t job,
  input  logic           job_full
);
  import bfca_pkg::*;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_K1   = 7'b0000010,
    F_K2   = 7'b0000100,
    F_H    = 7'b0001000,
    F_TAIL = 7'b0010000,
    F_FIN  = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_t;

  fstate_t      state_r, state_nxt;
  logic [255:0] key_r;
  logic [5:0]   len_r;
  logic [3:0]   nwords_r;
  logic [1:0]   tail_r;
  logic [3:0]   w_r, w_nxt;
  logic         pass_r, pass_nxt;
  logic [31:0]  k_r, k_nxt;
  logic [31:0]  h_r, h_nxt;
  job_t         job_r, job_nxt;

  logic [31:0]  word;
  logic [31:0]  tail_word;
  logic [31:0]  mul_op;
  logic [31:0]  prod;
  logic [31:0]  hfinal;
  logic [5:0]   len_sat;
  logic [3:0]   w_inc;

  assign word    = key_r[{w_r[2:0], 5'd0} +: 32];
  assign len_sat = (key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length;
  assign w_inc   = w_r + 4'd1;
  assign prod    = mul_op * MM_MUL;
  assign hfinal  = prod ^ (prod >> 15);

  always_comb begin
    unique case (tail_r)
      2'd1:    tail_word = word & 32'h0000_00ff;
      2'd2:    tail_word = word & 32'h0000_ffff;
      2'd3:    tail_word = word & 32'h00ff_ffff;
      default: tail_word = 32'd0;
    endcase
  end

  // one shared multiplier, the other operand is always the murmur constant
  always_comb begin
    unique case (state_r)
      F_K1:    mul_op = word;
      F_K2:    mul_op = k_r ^ (k_r >> 24);
      F_H:     mul_op = h_r;
      F_TAIL:  mul_op = h_r ^ tail_word;
      F_FIN:   mul_op = h_r ^ (h_r >> 13);
      default: mul_op = 32'd0;
    endcase
  end

  function automatic fstate_t first_step(input logic [3:0] nw, input logic [1:0] tl);
    fstate_t s;
    if (nw != 4'd0) begin
      s = F_K1;
    end else if (tl != 2'd0) begin
      s = F_TAIL;
    end else begin
      s = F_FIN;
    end
    return s;
  endfunction

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    pass_nxt  = pass_r;
    k_nxt     = k_r;
    h_nxt     = h_r;
    job_nxt   = job_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          job_nxt.add    = (command == CMD_ADD);
          job_nxt.status = ST_ABSENT;
          job_nxt.a      = 32'd0;
          job_nxt.b      = 32'd0;
          w_nxt          = 4'd0;
          pass_nxt       = 1'b0;
          h_nxt          = FIRST_SEED ^ {26'd0, len_sat};
          if (!enabled) begin
            job_nxt.kind   = JOB_DIRECT;
            job_nxt.status = ST_NOT_READY;
            state_nxt      = F_PUSH;
          end else if (command == CMD_CLEAR) begin
            job_nxt.kind = JOB_CLEAR;
            state_nxt    = F_PUSH;
          end else if (command == CMD_CHECK || command == CMD_ADD) begin
            job_nxt.kind = JOB_PROBE;
            state_nxt    = first_step(len_sat[5:2], len_sat[1:0]);
          end else begin
            // reserved command
            job_nxt.kind = JOB_DIRECT;
            state_nxt    = F_PUSH;
          end
        end
      end
      F_K1: begin
        k_nxt     = prod;
        state_nxt = F_K2;
      end
      F_K2: begin
        k_nxt     = prod;
        state_nxt = F_H;
      end
      F_H: begin
        h_nxt = prod ^ k_r;
        w_nxt = w_inc;
        if (w_inc < nwords_r) begin
          state_nxt = F_K1;
        end else if (tail_r != 2'd0) begin
          state_nxt = F_TAIL;
        end else begin
          state_nxt = F_FIN;
        end
      end
      F_TAIL: begin
        h_nxt     = prod;
        state_nxt = F_FIN;
      end
      F_FIN: begin
        if (!pass_r) begin
          job_nxt.a = hfinal;
          h_nxt     = hfinal ^ {26'd0, len_r};
          w_nxt     = 4'd0;
          pass_nxt  = 1'b1;
          state_nxt = first_step(nwords_r, tail_r);
        end else begin
          job_nxt.b = hfinal;
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!job_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      key_r    <= key;
      len_r    <= len_sat;
      nwords_r <= len_sat[5:2];
      tail_r   <= len_sat[1:0];
    end
    w_r    <= w_nxt;
    pass_r <= pass_nxt;
    k_r    <= k_nxt;
    h_r    <= h_nxt;
    job_r  <= job_nxt;
  end

  assign busy     = (state_r != F_IDLE);
  assign job_push = (state_r == F_PUSH) && !job_full;
  assign job      = job_r;

  property p_push_from_idle;
    @(posedge clk) disable iff (!rst_n)
      job_push |=> (state_r == F_IDLE);
  endproperty
  a_push_from_idle: assert property (p_push_from_idle)
    else $error("front did not return to idle after push");

  property p_no_start_busy;
    @(posedge clk) disable iff (!rst_n)
      (state_r == F_FIN && pass_r) |=> (state_r == F_PUSH);
  endproperty
  a_no_start_busy: assert property (p_no_start_busy)
    else $error("second hash pass did not lead to push");

  property p_word_bound;
    @(posedge clk) disable iff (!rst_n)
      (state_r == F_K1) |-> (w_r < nwords_r);
  endproperty
  a_word_bound: assert property (p_word_bound)
    else $error("word index past key length");

endmodule

@@ design/bfca_back.sv @@
// ----------------------------------------------------------------------------
// bfca_back
// probe sequencer: modulo unit, bit array read-modify-write, clear sweep
// ----------------------------------------------------------------------------
module bfca_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bfca_pkg::probe_cfg_t pcfg,
  input  logic                job_avail,
  input  bfca_pkg::job_t      job,
  output logic                job_pop,
  output logic                init_busy,
  output logic                out_valid,
  output logic [1:0]          out_status,
  input  logic                out_taken
);
  import bfca_pkg::*;

  typedef enum logic [5:0] {
    B_INIT = 6'b000001,
    B_IDLE = 6'b000010,
    B_MOD  = 6'b000100,
    B_RD   = 6'b001000,
    B_CHK  = 6'b010000,
    B_CLR  = 6'b100000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               add_r, add_nxt;
  logic [31:0]        s_r, s_nxt;
  logic [31:0]        b_r, b_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [5:0]         i_r, i_nxt;
  logic               miss_r, miss_nxt;
  logic [BYTE_AW-1:0] caddr_r, caddr_nxt;

  logic               ram_we;
  logic [BYTE_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic [BYTE_AW-1:0] byte_addr;
  logic [7:0]         bit_mask;
  logic               bit_set;
  logic [16:0]        rem_step;
  logic [17:0]        trial;

  assign byte_addr = rem_r[BYTE_AW+2:3];
  assign bit_mask  = 8'd1 << rem_r[2:0];
  assign bit_set   = |(ram_rdata & bit_mask);

  bfca_ram #(.WIDTH(8), .DEPTH(FILTER_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (byte_addr),
    .rdata (ram_rdata)
  );

  // four restoring remainder steps per cycle
  always_comb begin
    rem_step = rem_r;
    trial    = 18'd0;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_step, q_r[31-k]};
      if (trial >= {1'b0, pcfg.nbits}) begin
        trial = trial - {1'b0, pcfg.nbits};
      end
      rem_step = trial[16:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    add_nxt       = add_r;
    s_nxt         = s_r;
    b_nxt         = b_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    miss_nxt      = miss_r;
    caddr_nxt     = caddr_r;
    job_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = byte_addr;
    ram_wdata     = ram_rdata | bit_mask;

    if (out_valid_r && out_taken) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_INIT, B_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = caddr_r;
        ram_wdata = 8'd0;
        caddr_nxt = caddr_r + 1'b1;
        if (caddr_r == BYTE_AW'(FILTER_BYTES - 1)) begin
          state_nxt = B_IDLE;
          if (state_r == B_CLR) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_ABSENT;
          end
        end
      end
      B_IDLE: begin
        if (job_avail && !out_valid_r) begin
          job_pop   = 1'b1;
          add_nxt   = job.add;
          s_nxt     = job.a;
          b_nxt     = job.b;
          q_nxt     = job.a;
          rem_nxt   = 17'd0;
          step_nxt  = 3'd0;
          i_nxt     = 6'd0;
          miss_nxt  = 1'b0;
          caddr_nxt = '0;
          unique case (job.kind)
            JOB_CLEAR: state_nxt = B_CLR;
            JOB_PROBE: begin
              if (pcfg.probes == 6'd0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_PRESENT;
              end else begin
                state_nxt = B_MOD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = job.status;
            end
          endcase
        end
      end
      B_MOD: begin
        rem_nxt  = rem_step;
        q_nxt    = q_r << 4;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        state_nxt = B_CHK;
      end
      B_CHK: begin
        if (!bit_set) begin
          miss_nxt = 1'b1;
          ram_we   = add_r;
        end
        i_nxt    = i_r + 6'd1;
        s_nxt    = s_r + b_r;
        q_nxt    = s_r + b_r;
        rem_nxt  = 17'd0;
        step_nxt = 3'd0;
        if (i_r + 6'd1 == pcfg.probes) begin
          state_nxt     = B_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = (miss_r || !bit_set) ? ST_ABSENT : ST_PRESENT;
        end else begin
          state_nxt = B_MOD;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      out_valid_r <= 1'b0;
      caddr_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      caddr_r     <= caddr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    add_r    <= add_nxt;
    s_r      <= s_nxt;
    b_r      <= b_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    i_r      <= i_nxt;
    miss_r   <= miss_nxt;
  end

  assign init_busy  = (state_r == B_INIT);
  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  property p_init_quiet;
    @(posedge clk) disable iff (!rst_n)
      (state_r == B_INIT) |-> !out_valid_r;
  endproperty
  a_init_quiet: assert property (p_init_quiet)
    else $error("result shown during reset clear");

  property p_write_states;
    @(posedge clk) disable iff (!rst_n)
      ram_we |-> (state_r == B_CHK || state_r == B_CLR || state_r == B_INIT);
  endproperty
  a_write_states: assert property (p_write_states)
    else $error("bit array written outside update or clear");

  property p_pop_free_slot;
    @(posedge clk) disable iff (!rst_n)
      job_pop |-> !out_valid_r;
  endproperty
  a_pop_free_slot: assert property (p_pop_free_slot)
    else $error("job taken while result slot occupied");

  property p_rem_range;
    @(posedge clk) disable iff (!rst_n)
      (state_r == B_RD) |-> (rem_r < pcfg.nbits);
  endproperty
  a_rem_range: assert property (p_rem_range)
    else $error("probe index not reduced below bit count");

endmodule
